>>> rtl/bspa_pkg.sv
package bspa_pkg;

  localparam int TIME_W      = 24;
  localparam int SAMPLE_W    = 14;
  localparam int AREA_W      = 48;
  localparam int COUNT_OUT_W = 11;
  localparam int STATUS_W    = 2;
  localparam int FRAC_BITS   = 8;
  localparam int NUM_CH      = 3;
  localparam int CH_W        = 2;

  localparam int MAX_SAMPLES_DEF = 1024;

  localparam logic [TIME_W-1:0] LIMIT_RESET = TIME_W'(4000);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OVF   = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic            accept;
    logic            snap;
    logic            prod;
    logic            diff;
    logic            mul_step;
    logic            div_step;
    logic            store;
    logic            load_out;
    logic            clear;
    logic [CH_W-1:0] chan;
  } bspa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ok;
  } bspa_stat_t;

  // sample counter width, able to hold the maximum itself
  function automatic int cnt_w(int max_samples);
    return $clog2(max_samples + 1);
  endfunction

  // running sum width
  function automatic int sum_w(int max_samples);
    return SAMPLE_W + $clog2(max_samples);
  endfunction

  // count times sum product width
  function automatic int prod_w(int max_samples);
    return cnt_w(max_samples) + sum_w(max_samples) + 1;
  endfunction

  // difference of products, magnitude width
  function automatic int mag_w(int max_samples);
    return prod_w(max_samples) + 1;
  endfunction

  // scaled numerator width
  function automatic int num_w(int max_samples);
    return mag_w(max_samples) + TIME_W + FRAC_BITS;
  endfunction

endpackage

>>> rtl/bspa_ctrl.sv
module bspa_ctrl
  import bspa_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last_sample,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  bspa_stat_t stat,
  output bspa_cmd_t  cmd
);

  localparam int NW        = num_w(MAX_SAMPLES);
  localparam int MUL_STEPS = TIME_W + FRAC_BITS;
  localparam int SCW       = $clog2(NW);

  localparam logic [SCW-1:0]  MUL_LAST = SCW'(MUL_STEPS - 1);
  localparam logic [SCW-1:0]  DIV_LAST = SCW'(NW - 1);
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(NUM_CH - 1);

  typedef enum logic [2:0] {
    S_ACCUM,
    S_PROD,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_STORE,
    S_FINISH
  } state_t;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] chan_r, chan_nxt;
  logic [SCW-1:0]  step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_free;

  assign in_ready  = (state_r == S_ACCUM);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    chan_nxt      = chan_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.chan      = chan_r;
    cmd.accept    = accept;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_ACCUM: begin
        if (accept && in_last_sample) begin
          cmd.snap  = 1'b1;
          chan_nxt  = '0;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = stat.ok ? S_DIFF : S_FINISH;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (step_r == MUL_LAST) begin
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = S_STORE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (chan_r == CH_LAST) begin
          state_nxt = S_FINISH;
        end else begin
          chan_nxt  = chan_r + 1'b1;
          state_nxt = S_PROD;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load_out  = 1'b1;
          cmd.clear     = 1'b1;
          out_valid_nxt = 1'b1;
          chan_nxt      = '0;
          state_nxt     = S_ACCUM;
        end
      end
      default: begin
        state_nxt = S_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACCUM;
      chan_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/bspa_dp.sv
module bspa_dp
  import bspa_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [TIME_W-1:0]          cfg_limit,
  input  logic [TIME_W-1:0]          in_time_stamp,
  input  logic signed [SAMPLE_W-1:0] in_sample_a,
  input  logic signed [SAMPLE_W-1:0] in_sample_b,
  input  logic signed [SAMPLE_W-1:0] in_sample_c,
  input  bspa_cmd_t                  cmd,
  output bspa_stat_t                 stat,
  output logic signed [AREA_W-1:0]   out_area_a,
  output logic signed [AREA_W-1:0]   out_area_b,
  output logic signed [AREA_W-1:0]   out_area_c,
  output logic [COUNT_OUT_W-1:0]     out_baseline_count,
  output logic [COUNT_OUT_W-1:0]     out_sample_count,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int CW   = cnt_w(MAX_SAMPLES);
  localparam int SW   = sum_w(MAX_SAMPLES);
  localparam int PRW  = prod_w(MAX_SAMPLES);
  localparam int DW   = mag_w(MAX_SAMPLES);
  localparam int NW   = num_w(MAX_SAMPLES);
  localparam int MW   = TIME_W + FRAC_BITS;
  localparam int DENW = 2 * CW;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

  // configuration
  logic [TIME_W-1:0] limit_r;

  // accumulation
  logic [TIME_W-1:0]    first_r, first_nxt;
  logic                 inbase_r, inbase_nxt;
  logic signed [SW-1:0] bsum_r [NUM_CH];
  logic signed [SW-1:0] bsum_nxt [NUM_CH];
  logic signed [SW-1:0] tsum_r [NUM_CH];
  logic signed [SW-1:0] tsum_nxt [NUM_CH];
  logic [CW-1:0]        nb_r, nb_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [SW-1:0] samp [NUM_CH];

  // area computation
  logic [TIME_W-1:0]     ta_r, ta_nxt;
  logic                  tneg_r, tneg_nxt;
  status_t               status_r, status_nxt;
  logic signed [PRW-1:0] p1_r, p1_nxt;
  logic signed [PRW-1:0] p2_r, p2_nxt;
  logic [DENW-1:0]       den_r, den_nxt;
  logic [DW-1:0]         da_r, da_nxt;
  logic                  dneg_r, dneg_nxt;
  logic [MW-1:0]         mq_r, mq_nxt;
  logic [NW-1:0]         nq_r, nq_nxt;
  logic [DENW-1:0]       rem_r, rem_nxt;
  logic [AREA_W-1:0]     area_r [NUM_CH];
  logic [AREA_W-1:0]     area_nxt [NUM_CH];

  // output register
  logic [AREA_W-1:0]      oarea_r [NUM_CH];
  logic [COUNT_OUT_W-1:0] onb_r;
  logic [COUNT_OUT_W-1:0] on_r;
  status_t                ostatus_r;

  // combinational helpers
  logic signed [PRW-1:0] nb_ext, n_ext, tsum_ext, bsum_ext;
  logic signed [DW-1:0]  dnum;
  logic [DENW:0]         rem_sh;
  logic                  rem_ge;
  logic [AREA_W-1:0]     quot;
  logic [CW+COUNT_OUT_W-1:0] nb_wide, n_wide;

  assign samp[0] = SW'(in_sample_a);
  assign samp[1] = SW'(in_sample_b);
  assign samp[2] = SW'(in_sample_c);

  assign stat.ok = (status_r == ST_OK);

  // waveform accumulation
  always_comb begin
    first_nxt  = first_r;
    inbase_nxt = inbase_r;
    bsum_nxt   = bsum_r;
    tsum_nxt   = tsum_r;
    nb_nxt     = nb_r;
    n_nxt      = n_r;
    ovf_nxt    = ovf_r;

    if (cmd.accept) begin
      if (n_r == MAX_CNT) begin
        ovf_nxt = 1'b1;
      end else begin
        if (n_r == '0) begin
          first_nxt = in_time_stamp;
        end
        if (inbase_r && (in_time_stamp < limit_r)) begin
          for (int c = 0; c < NUM_CH; c++) begin
            bsum_nxt[c] = bsum_r[c] + samp[c];
          end
          nb_nxt = nb_r + 1'b1;
        end else begin
          inbase_nxt = 1'b0;
        end
        for (int c = 0; c < NUM_CH; c++) begin
          tsum_nxt[c] = tsum_r[c] + samp[c];
        end
        n_nxt = n_r + 1'b1;
      end
    end

    if (cmd.clear) begin
      first_nxt  = '0;
      inbase_nxt = 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        bsum_nxt[c] = '0;
        tsum_nxt[c] = '0;
      end
      nb_nxt  = '0;
      n_nxt   = '0;
      ovf_nxt = 1'b0;
    end
  end

  // shared multiply and divide unit
  always_comb begin
    ta_nxt     = ta_r;
    tneg_nxt   = tneg_r;
    status_nxt = status_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    den_nxt    = den_r;
    da_nxt     = da_r;
    dneg_nxt   = dneg_r;
    mq_nxt     = mq_r;
    nq_nxt     = nq_r;
    rem_nxt    = rem_r;
    area_nxt   = area_r;

    nb_ext   = PRW'(signed'({1'b0, nb_r}));
    n_ext    = PRW'(signed'({1'b0, n_r}));
    tsum_ext = PRW'(tsum_r[cmd.chan]);
    bsum_ext = PRW'(bsum_r[cmd.chan]);
    dnum     = DW'(p1_r) - DW'(p2_r);
    rem_sh   = {rem_r, nq_r[NW-1]};
    rem_ge   = (rem_sh >= {1'b0, den_r});
    quot     = nq_r[AREA_W-1:0];

    if (cmd.snap) begin
      // time difference taken against the updated first time stamp
      tneg_nxt = (in_time_stamp < first_nxt);
      ta_nxt   = tneg_nxt ? (first_nxt - in_time_stamp) : (in_time_stamp - first_nxt);
      if (ovf_nxt) begin
        status_nxt = ST_OVF;
      end else if (nb_nxt == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_OK;
      end
      for (int c = 0; c < NUM_CH; c++) begin
        area_nxt[c] = '0;
      end
    end

    if (cmd.prod) begin
      p1_nxt = nb_ext * tsum_ext;
      p2_nxt = n_ext * bsum_ext;
    end

    if (cmd.diff) begin
      dneg_nxt = dnum[DW-1];
      da_nxt   = dneg_nxt ? DW'(-dnum) : DW'(dnum);
      den_nxt  = DENW'(n_r) * DENW'(nb_r);
      mq_nxt   = {ta_r, FRAC_BITS'(0)};
      nq_nxt   = '0;
      rem_nxt  = '0;
    end

    if (cmd.mul_step) begin
      // shift and add, multiplier MSB first
      nq_nxt = {nq_r[NW-2:0], 1'b0} + (mq_r[MW-1] ? NW'(da_r) : NW'(0));
      mq_nxt = {mq_r[MW-2:0], 1'b0};
    end

    if (cmd.div_step) begin
      // restoring division, quotient bits shift in behind the numerator
      rem_nxt = rem_ge ? DENW'(rem_sh - {1'b0, den_r}) : rem_sh[DENW-1:0];
      nq_nxt  = {nq_r[NW-2:0], rem_ge};
    end

    if (cmd.store) begin
      area_nxt[cmd.chan] = (tneg_r ^ dneg_r) ? (AREA_W'(0) - quot) : quot;
    end
  end

  assign nb_wide = {COUNT_OUT_W'(0), nb_r};
  assign n_wide  = {COUNT_OUT_W'(0), n_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      first_r  <= '0;
      inbase_r <= 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        bsum_r[c] <= '0;
        tsum_r[c] <= '0;
      end
      nb_r     <= '0;
      n_r      <= '0;
      ovf_r    <= 1'b0;
      status_r <= ST_OK;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_limit;
      end
      first_r  <= first_nxt;
      inbase_r <= inbase_nxt;
      bsum_r   <= bsum_nxt;
      tsum_r   <= tsum_nxt;
      nb_r     <= nb_nxt;
      n_r      <= n_nxt;
      ovf_r    <= ovf_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ta_r   <= ta_nxt;
    tneg_r <= tneg_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    den_r  <= den_nxt;
    da_r   <= da_nxt;
    dneg_r <= dneg_nxt;
    mq_r   <= mq_nxt;
    nq_r   <= nq_nxt;
    rem_r  <= rem_nxt;
    area_r <= area_nxt;
    if (cmd.load_out) begin
      oarea_r   <= area_r;
      onb_r     <= nb_wide[COUNT_OUT_W-1:0];
      on_r      <= n_wide[COUNT_OUT_W-1:0];
      ostatus_r <= status_r;
    end
  end

  assign out_area_a         = oarea_r[0];
  assign out_area_b         = oarea_r[1];
  assign out_area_c         = oarea_r[2];
  assign out_baseline_count = onb_r;
  assign out_sample_count   = on_r;
  assign out_status         = ostatus_r;

endmodule

>>> rtl/baseline_subtracted_pulse_area.sv
// Baseline-subtracted pulse area for a three-channel digitised waveform. Samples are taken
// one per clock while in_ready is high; the leading samples whose time stamp lies below
// cfg_baseline_time_limit form the baseline. The sample marked last ends the waveform,
// after which in_ready drops while one shared shift-and-add multiplier and restoring
// divider work through the three channels in turn, and stays low while the previous result
// is still held in the output register. A flagged waveform skips the arithmetic and goes
// straight to that wait. The finished result then sits in that register until taken, and
// the next waveform may stream in meanwhile. Status 1 (empty baseline) and 2 (more than
// MAX_SAMPLES samples; extra samples are dropped) give zero areas. Write the limit only
// while no waveform is in progress.
module baseline_subtracted_pulse_area
  import bspa_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [TIME_W-1:0]          cfg_baseline_time_limit,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [TIME_W-1:0]          in_time_stamp,
  input  logic signed [SAMPLE_W-1:0] in_sample_a,
  input  logic signed [SAMPLE_W-1:0] in_sample_b,
  input  logic signed [SAMPLE_W-1:0] in_sample_c,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [AREA_W-1:0]   out_area_a,
  output logic signed [AREA_W-1:0]   out_area_b,
  output logic signed [AREA_W-1:0]   out_area_c,
  output logic [COUNT_OUT_W-1:0]     out_baseline_count,
  output logic [COUNT_OUT_W-1:0]     out_sample_count,
  output logic [STATUS_W-1:0]        out_status
);

  bspa_cmd_t  cmd;
  bspa_stat_t stat;

  assign cfg_ready = 1'b1;

  bspa_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_sample (in_last_sample),
    .in_ready       (in_ready),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .stat           (stat),
    .cmd            (cmd)
  );

  bspa_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_limit          (cfg_baseline_time_limit),
    .in_time_stamp      (in_time_stamp),
    .in_sample_a        (in_sample_a),
    .in_sample_b        (in_sample_b),
    .in_sample_c        (in_sample_c),
    .cmd                (cmd),
    .stat               (stat),
    .out_area_a         (out_area_a),
    .out_area_b         (out_area_b),
    .out_area_c         (out_area_c),
    .out_baseline_count (out_baseline_count),
    .out_sample_count   (out_sample_count),
    .out_status         (out_status)
  );

  // a flagged waveform never carries an area
  a_flag_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_area_a == '0) && (out_area_b == '0) && (out_area_c == '0))
    else $error("flagged result with non-zero area");

  // the last sample of a waveform starts the area computation
  a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_sample |=> !in_ready)
    else $error("input still open after last sample");

  // the arithmetic unit never runs while samples stream in
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.mul_step || cmd.div_step || cmd.load_out || cmd.store))
    else $error("arithmetic active while input open");

  // a result is only loaded together with the clear of its accumulators
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> cmd.clear)
    else $error("result loaded without clearing the waveform");

endmodule

>>> test/baseline_subtracted_pulse_area_tb.sv
module baseline_subtracted_pulse_area_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bspa_pkg::*;

  localparam int MAX_WF        = 1024;
  localparam int SUM_W         = 24;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 14'sd8191;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = -14'sd8192;

  typedef struct packed {
    logic [AREA_W-1:0]      area_a;
    logic [AREA_W-1:0]      area_b;
    logic [AREA_W-1:0]      area_c;
    logic [COUNT_OUT_W-1:0] base_cnt;
    logic [COUNT_OUT_W-1:0] samp_cnt;
    status_t                status;
  } pulse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [TIME_W-1:0]          cfg_baseline_time_limit;
  logic                       in_valid;
  logic                       in_ready;
  logic [TIME_W-1:0]          in_time_stamp;
  logic signed [SAMPLE_W-1:0] in_sample_a;
  logic signed [SAMPLE_W-1:0] in_sample_b;
  logic signed [SAMPLE_W-1:0] in_sample_c;
  logic                       in_last_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [AREA_W-1:0]   out_area_a;
  logic signed [AREA_W-1:0]   out_area_b;
  logic signed [AREA_W-1:0]   out_area_c;
  logic [COUNT_OUT_W-1:0]     out_baseline_count;
  logic [COUNT_OUT_W-1:0]     out_sample_count;
  logic [STATUS_W-1:0]        out_status;

  // waveform accumulator mirror
  logic [TIME_W-1:0]      limit_model;
  logic [TIME_W-1:0]      wf_first_time;
  logic                   wf_in_base;
  logic signed [SUM_W-1:0] base_sum [NUM_CH];
  logic signed [SUM_W-1:0] tot_sum [NUM_CH];
  logic [COUNT_OUT_W-1:0] wf_base_cnt;
  logic [COUNT_OUT_W-1:0] wf_cnt;
  logic                   wf_ovf;

  pulse_result_t expected_pulses [$];
  int error_count   = 0;
  int samples_sent  = 0;
  int cycle_count   = 0;
  bit src_gaps;
  bit sink_stalls;
  bit long_hold;

  baseline_subtracted_pulse_area u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_baseline_time_limit (cfg_baseline_time_limit),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_time_stamp           (in_time_stamp),
    .in_sample_a             (in_sample_a),
    .in_sample_b             (in_sample_b),
    .in_sample_c             (in_sample_c),
    .in_last_sample          (in_last_sample),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_area_a              (out_area_a),
    .out_area_b              (out_area_b),
    .out_area_c              (out_area_c),
    .out_baseline_count      (out_baseline_count),
    .out_sample_count        (out_sample_count),
    .out_status              (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void restart_waveform();
    int c;
    wf_first_time = '0;
    wf_in_base    = 1'b1;
    for (c = 0; c < NUM_CH; c++) begin
      base_sum[c] = '0;
      tot_sum[c]  = '0;
    end
    wf_base_cnt = '0;
    wf_cnt      = '0;
    wf_ovf      = 1'b0;
  endfunction

  // (t_last - t_first) * (nb*S_total - n*S_base) * 256 / (n*nb), truncated toward zero
  function automatic logic [AREA_W-1:0] pulse_area(int ch, logic [TIME_W-1:0] t_last);
    longint td, dn, ta, da, nn, nb;
    logic [127:0] num, quo;
    logic [AREA_W-1:0] mag;
    td  = longint'(t_last) - longint'(wf_first_time);
    nn  = longint'(wf_cnt);
    nb  = longint'(wf_base_cnt);
    dn  = nb * longint'(tot_sum[ch]) - nn * longint'(base_sum[ch]);
    ta  = (td < 0) ? -td : td;
    da  = (dn < 0) ? -dn : dn;
    num = ({64'd0, ta} * {64'd0, da}) << FRAC_BITS;
    quo = num / {64'd0, nn * nb};
    mag = quo[AREA_W-1:0];
    return ((td < 0) != (dn < 0)) ? -mag : mag;
  endfunction

  function automatic void fold_sample(logic [TIME_W-1:0] ts, logic signed [SAMPLE_W-1:0] sa,
                                      logic signed [SAMPLE_W-1:0] sb,
                                      logic signed [SAMPLE_W-1:0] sc, logic last);
    logic signed [SAMPLE_W-1:0] s [NUM_CH];
    logic [AREA_W-1:0] ar [NUM_CH];
    pulse_result_t r;
    status_t st;
    int c;
    s[0] = sa;
    s[1] = sb;
    s[2] = sc;
    if (wf_cnt >= MAX_WF) begin
      // drop the sample, keep the count saturated
      wf_ovf = 1'b1;
    end else begin
      if (wf_cnt == 0) wf_first_time = ts;
      if (wf_in_base && ts < limit_model) begin
        for (c = 0; c < NUM_CH; c++) base_sum[c] = base_sum[c] + s[c];
        wf_base_cnt++;
      end else begin
        wf_in_base = 1'b0;
      end
      for (c = 0; c < NUM_CH; c++) tot_sum[c] = tot_sum[c] + s[c];
      wf_cnt++;
    end
    if (last) begin
      if (wf_ovf) st = ST_OVF;
      else if (wf_base_cnt == 0) st = ST_EMPTY;
      else st = ST_OK;
      for (c = 0; c < NUM_CH; c++) ar[c] = (st == ST_OK) ? pulse_area(c, ts) : '0;
      r.area_a   = ar[0];
      r.area_b   = ar[1];
      r.area_c   = ar[2];
      r.base_cnt = wf_base_cnt;
      r.samp_cnt = wf_cnt;
      r.status   = st;
      expected_pulses = {expected_pulses, r};
      restart_waveform();
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] expv, logic [63:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, actual %0d", name, $signed(expv), $signed(actv));
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_pulses
    pulse_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pulses.size() == 0) begin
        $error("result transfer with no pulse pending");
        error_count++;
      end else begin
        want = expected_pulses.pop_front();
        check_field("area_a", $signed(want.area_a), out_area_a);
        check_field("area_b", $signed(want.area_b), out_area_b);
        check_field("area_c", $signed(want.area_c), out_area_c);
        check_field("baseline_count", want.base_cnt, out_baseline_count);
        check_field("sample_count", want.samp_cnt, out_sample_count);
        check_field("status", want.status, out_status);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink_ctrl
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(logic [TIME_W-1:0] ts, logic signed [SAMPLE_W-1:0] sa,
                             logic signed [SAMPLE_W-1:0] sb, logic signed [SAMPLE_W-1:0] sc,
                             logic last);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_time_stamp  <= ts;
    in_sample_a    <= sa;
    in_sample_b    <= sb;
    in_sample_c    <= sc;
    in_last_sample <= last;
    do @(posedge clk); while (!in_ready);
    fold_sample(ts, sa, sb, sc, last);
    samples_sent++;
    @(negedge clk);
  endtask

  // hold the source idle until every pulse is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pulses.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [TIME_W-1:0] value);
    cfg_valid               <= 1'b1;
    cfg_baseline_time_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_waveform();
    int n, k, step, ped, amp, i, c, v;
    logic [TIME_W-1:0] t0, ts;
    logic signed [SAMPLE_W-1:0] s [NUM_CH];
    bit noisy;
    n     = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
    k     = $urandom_range(0, n);
    step  = $urandom_range(1, 64);
    ped   = int'($urandom_range(0, 2000)) - 1000;
    amp   = int'($urandom_range(0, 16000)) - 8000;
    noisy = ($urandom_range(0, 9) == 0);
    // place the first k samples below the limit, when it leaves room for them and the time stamps are not noisy
    t0 = (limit_model > k * step) ? TIME_W'(limit_model - k * step) : '0;
    for (i = 0; i < n; i++) begin
      ts = noisy ? TIME_W'($urandom) : TIME_W'(t0 + i * step);
      for (c = 0; c < NUM_CH; c++) begin
        if ($urandom_range(0, 7) == 0) begin
          s[c] = SAMPLE_W'($urandom);
        end else begin
          v = ped + int'($urandom_range(0, 40)) - 20 + ((i >= k) ? amp : 0);
          s[c] = (v > 8191) ? SMP_MAX : ((v < -8192) ? SMP_MIN : SAMPLE_W'(v));
        end
      end
      send_sample(ts, s[0], s[1], s[2], i == n - 1);
    end
  endtask

  task automatic test_reset_limit();
    send_sample(24'd100,  SMP_MAX, SMP_MIN, 14'sd0, 1'b0);
    send_sample(24'd3999, SMP_MIN, SMP_MAX, 14'sd1, 1'b0);
    send_sample(24'd4000, SMP_MAX, SMP_MAX, SMP_MIN, 1'b0);
    // below the limit again, but the baseline has already closed
    send_sample(24'd2000, -14'sd1, SMP_MIN, SMP_MAX, 1'b0);
    send_sample(24'd5000, 14'sd100, 14'sd200, -14'sd300, 1'b1);
    send_sample(24'd10, 14'sd5, 14'sd5, 14'sd5, 1'b1);
    send_sample(24'd0, -14'sd7, 14'sd3, 14'sd9, 1'b0);
    send_sample(24'd3999, 14'sd2, -14'sd4, 14'sd6, 1'b1);
    drain();
  endtask

  task automatic test_empty_baseline();
    send_sample(24'd4000, 14'sd500, -14'sd500, 14'sd50, 1'b0);
    send_sample(24'd10, 14'sd1, 14'sd2, 14'sd3, 1'b1);
    send_sample(TIME_MAX, SMP_MIN, SMP_MIN, SMP_MIN, 1'b1);
    drain();
  endtask

  task automatic test_time_backward();
    send_sample(24'd3000, 14'sd0, 14'sd0, 14'sd0, 1'b0);
    send_sample(24'd3500, 14'sd10, -14'sd10, 14'sd0, 1'b0);
    send_sample(24'd4100, SMP_MAX, SMP_MIN, 14'sd500, 1'b0);
    send_sample(24'd4200, 14'sd7000, -14'sd7000, 14'sd1, 1'b0);
    send_sample(24'd1000, 14'sd0, 14'sd0, 14'sd0, 1'b1);
    drain();
  endtask

  task automatic test_limit_extremes();
    write_limit('0);
    send_sample(24'd0, 14'sd3, 14'sd3, 14'sd3, 1'b0);
    send_sample(24'd0, 14'sd4, 14'sd4, 14'sd4, 1'b1);
    drain();
    write_limit(TIME_MAX);
    send_sample(TIME_MAX - 24'd1, SMP_MIN, SMP_MAX, -14'sd1, 1'b0);
    send_sample(24'd0, SMP_MAX, SMP_MIN, 14'sd1, 1'b0);
    send_sample(TIME_MAX, SMP_MAX, SMP_MAX, SMP_MAX, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    int w;
    long_hold = 1'b1;
    // keep offering waveforms while results are held back
    for (w = 0; w < 6; w++) send_random_waveform();
    drain();
  endtask

  task automatic test_sample_overflow();
    int i;
    // overflow outranks the empty baseline
    write_limit('0);
    for (i = 0; i < MAX_WF + 2; i++)
      send_sample(TIME_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                  SAMPLE_W'($urandom), i == MAX_WF + 1);
    drain();
  endtask

  task automatic test_random_waveforms(int count, logic [TIME_W-1:0] limit);
    int stop_at;
    write_limit(limit);
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) send_random_waveform();
    drain();
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_valid               = 1'b0;
    cfg_baseline_time_limit = LIMIT_RESET;
    in_valid                = 1'b0;
    in_time_stamp           = '0;
    in_sample_a             = '0;
    in_sample_b             = '0;
    in_sample_c             = '0;
    in_last_sample          = 1'b0;
    src_gaps                = 1'b1;
    sink_stalls             = 1'b1;
    long_hold               = 1'b0;
    limit_model             = LIMIT_RESET;
    restart_waveform();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_limit();
    test_empty_baseline();
    test_time_backward();
    test_limit_extremes();
    test_backpressure();
    test_sample_overflow();
    test_random_waveforms(80, TIME_W'($urandom_range(0, 65535)));
    test_random_waveforms(60, TIME_MAX);
    test_random_waveforms(60, '0);
    test_random_waveforms(60, LIMIT_RESET);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    test_random_waveforms(120, TIME_W'($urandom));

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> baseline_subtracted_pulse_area.f
rtl/bspa_pkg.sv
rtl/bspa_ctrl.sv
rtl/bspa_dp.sv
rtl/baseline_subtracted_pulse_area.sv
test/baseline_subtracted_pulse_area_tb.sv
